// ===== rtl/gmps_pkg.sv =====
// Package for the grid maximum path sum block with skipped cells.
// Holds sizes, sum types, the register index codes and shared helper functions.
// Depends on nothing; every other file of the block takes it by scoped names.
`timescale 1ns / 1ps

package gmps_pkg;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_SKIPS = 2;
  localparam int LEVELS    = MAX_SKIPS + 1;

  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SIZE_W  = 11;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 32;

  typedef logic signed [VALUE_W-1:0]    value_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic signed [SUM_W:0]        wide_sum_t;
  typedef logic [LEVELS-1:0][SUM_W-1:0] level_sums_t;
  typedef logic [SIZE_W-1:0]            size_t;

  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  // A size of zero behaves as one; a size beyond the limit behaves as the limit.
  function automatic size_t clamp_size(input size_t v, input size_t limit);
    size_t r;
    if (v == '0) begin
      r = size_t'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturate a one-bit-wider sum back to the sum width.
  function automatic sum_t sat_sum(input wide_sum_t x);
    sum_t r;
    if (x[SUM_W] != x[SUM_W-1]) begin
      r = x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = x[SUM_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/gmps_cell_if.sv =====
// Input channel of the grid path block: one cell value per beat.
// Depends on gmps_pkg for the value type.
`timescale 1ns / 1ps

interface gmps_cell_if;
  logic            valid;
  logic            ready;
  gmps_pkg::value_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink   (input valid, input cell_value, output ready);
endinterface

// ===== rtl/gmps_result_if.sv =====
// Output channel of the grid path block: one best path sum per beat.
// Depends on gmps_pkg for the sum type.
`timescale 1ns / 1ps

interface gmps_result_if;
  logic           valid;
  logic           ready;
  gmps_pkg::sum_t best_amount;

  modport source (output valid, output best_amount, input ready);
  modport sink   (input valid, input best_amount, output ready);
endinterface

// ===== rtl/gmps_cfg_if.sv =====
// Register write channel of the grid path block: index and data per beat.
// Depends on gmps_pkg for the register index codes and the size width.
`timescale 1ns / 1ps

interface gmps_cfg_if;
  logic               valid;
  logic               ready;
  gmps_pkg::cfg_reg_t index;
  gmps_pkg::size_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/grid_max_path_sum_with_skips.sv =====
// A cell accepted is registered in the lookup stage and writes its column update as it
// leaves; a grid's result is loaded into the output register as its last cell leaves,
// which waits while the output holds an untaken result. Throughput: one cell per cycle
// while that stage does not stall, set by the single column memory read for one cell while
// the cell before it writes back. Reset (rst, synchronous, active high): both sizes return
// to 1, the position to the top left cell, the pipeline and output empty; memory not cleared.
`timescale 1ns / 1ps

module grid_max_path_sum_with_skips (
  input  logic                 clk,
  input  logic                 rst,
  gmps_cell_if.sink            cells,
  gmps_result_if.source        results,
  gmps_cfg_if.sink             cfg
);

  // Configuration.
  gmps_pkg::size_t num_rows;
  gmps_pkg::size_t num_cols;

  // Position of the next cell to be accepted.
  logic [gmps_pkg::ROW_W-1:0] row_index;
  logic [gmps_pkg::COL_W-1:0] col_index;

  // Lookup stage.
  logic                       s1_valid;
  gmps_pkg::value_t           s1_value;
  logic [gmps_pkg::COL_W-1:0] s1_col;
  logic                       s1_has_up;
  logic                       s1_has_left;
  logic                       s1_last;

  // Column memory holding the row above, all skip levels in one word.
  gmps_pkg::level_sums_t col_mem [gmps_pkg::MAX_COLS];
  gmps_pkg::level_sums_t above_q;
  gmps_pkg::level_sums_t left_sums;
  gmps_pkg::level_sums_t next_sums;

  logic            out_valid;
  gmps_pkg::sum_t  best_amount;

  logic                       accept;
  logic                       s1_go;
  logic                       in_ready;
  gmps_pkg::size_t            rows_eff;
  gmps_pkg::size_t            cols_eff;
  logic [gmps_pkg::COL_W-1:0] rd_col;
  logic                       last_col;
  logic                       last_row;

  assign s1_go    = s1_valid && (!s1_last || !out_valid || results.ready);
  assign in_ready = !s1_valid || s1_go;
  assign accept   = cells.valid && in_ready;

  assign cells.ready         = in_ready;
  assign results.valid       = out_valid;
  assign results.best_amount = best_amount;
  assign cfg.ready           = 1'b1;

  assign rows_eff = gmps_pkg::clamp_size(num_rows, gmps_pkg::SIZE_W'(gmps_pkg::MAX_ROWS));
  assign cols_eff = gmps_pkg::clamp_size(num_cols, gmps_pkg::SIZE_W'(gmps_pkg::MAX_COLS));

  assign rd_col = (gmps_pkg::SIZE_W'(col_index) > gmps_pkg::SIZE_W'(gmps_pkg::MAX_COLS - 1))
                ? gmps_pkg::COL_W'(gmps_pkg::MAX_COLS - 1) : col_index;

  assign last_col = (gmps_pkg::SIZE_W'(rd_col) + gmps_pkg::SIZE_W'(1)) >= cols_eff;
  assign last_row = (gmps_pkg::SIZE_W'(row_index) + gmps_pkg::SIZE_W'(1)) >= rows_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= gmps_pkg::size_t'(1);
      num_cols <= gmps_pkg::size_t'(1);
    end else if (cfg.valid) begin
      case (cfg.index)
        gmps_pkg::REG_NUM_ROWS: num_rows <= cfg.data;
        gmps_pkg::REG_NUM_COLS: num_cols <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index <= '0;
      col_index <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_index <= '0;
        row_index <= last_row ? '0 : row_index + 1'b1;
      end else begin
        col_index <= rd_col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value    <= cells.cell_value;
      s1_col      <= rd_col;
      s1_has_up   <= (row_index != '0);
      s1_has_left <= (rd_col != '0);
      s1_last     <= last_col && last_row;
    end
  end

  // Write-first memory: when the cell in the lookup stage writes the entry that
  // the new cell reads (single-column grids), the fresh sums are forwarded.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      col_mem[s1_col] <= next_sums;
    end
    if (accept) begin
      if (s1_go && (s1_col == rd_col)) begin
        above_q <= next_sums;
      end else begin
        above_q <= col_mem[rd_col];
      end
    end
  end

  function automatic gmps_pkg::sum_t level_best(
    input logic             has_up,
    input logic             has_left,
    input logic             can_skip,
    input gmps_pkg::value_t v,
    input gmps_pkg::sum_t   up,
    input gmps_pkg::sum_t   up_lower,
    input gmps_pkg::sum_t   left,
    input gmps_pkg::sum_t   left_lower
  );
    gmps_pkg::wide_sum_t best;
    gmps_pkg::wide_sum_t cand;
    gmps_pkg::wide_sum_t v_ext;
    logic                skip_ok;
    best    = '0;
    v_ext   = gmps_pkg::wide_sum_t'(v);
    skip_ok = can_skip && v[gmps_pkg::VALUE_W-1];
    if (has_up) begin
      best = gmps_pkg::wide_sum_t'(up) + v_ext;
      cand = gmps_pkg::wide_sum_t'(up_lower);
      if (skip_ok && (cand > best)) begin
        best = cand;
      end
    end
    if (has_left) begin
      cand = gmps_pkg::wide_sum_t'(left) + v_ext;
      if (!has_up || (cand > best)) begin
        best = cand;
      end
      cand = gmps_pkg::wide_sum_t'(left_lower);
      if (skip_ok && (cand > best)) begin
        best = cand;
      end
    end
    return gmps_pkg::sat_sum(best);
  endfunction

  always_comb begin
    if (!s1_has_up && !s1_has_left) begin
      // Top left cell: no skip keeps the value, any skip may drop a negative one.
      next_sums[0] = gmps_pkg::sum_t'(s1_value);
      for (int k = 1; k < gmps_pkg::LEVELS; k++) begin
        next_sums[k] = s1_value[gmps_pkg::VALUE_W-1] ? '0 : gmps_pkg::sum_t'(s1_value);
      end
    end else begin
      next_sums[0] = level_best(s1_has_up, s1_has_left, 1'b0, s1_value,
                                above_q[0], above_q[0], left_sums[0], left_sums[0]);
      for (int k = 1; k < gmps_pkg::LEVELS; k++) begin
        next_sums[k] = level_best(s1_has_up, s1_has_left, 1'b1, s1_value,
                                  above_q[k], above_q[k-1], left_sums[k], left_sums[k-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_sums <= '0;
    end else if (s1_go) begin
      left_sums <= s1_last ? '0 : next_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      best_amount <= next_sums[gmps_pkg::MAX_SKIPS];
    end
  end

  a_result_follows_last_cell: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> out_valid && (best_amount == $past(next_sums[gmps_pkg::MAX_SKIPS])))
    else $error("grid result not loaded after the last cell");

  a_stage_holds_when_stalled: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col) && $stable(above_q))
    else $error("lookup stage changed while stalled");

  a_empty_stage_takes_beat: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> cells.ready)
    else $error("input blocked with an empty lookup stage");

  a_grid_end_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> (row_index == '0) && (col_index == '0))
    else $error("position not reset at grid end");

endmodule
